@@ src/psp_pkg.sv @@
package psp_pkg;

    // Column item geometry
    localparam int NUM_BASES    = 5;
    localparam int CNT_W        = 10;
    localparam int MAX_COVERAGE = 1023;
    localparam int IN_DATA_W    = 64;

    // Arithmetic widths
    localparam int W_W     = 5;    // signed weight
    localparam int SUM_W   = 13;   // sum of five clamped base counts
    localparam int SQ_W    = 2 * CNT_W;
    localparam int SQSUM_W = 23;   // sum of five squares
    localparam int S2_W    = 2 * SUM_W;
    localparam int GS_W    = CNT_W + SUM_W;
    localparam int PAIR_W  = 24;   // sum over pairs of distinct base counts
    localparam int PROD_W  = 30;   // weight times a term, signed
    localparam int COL_W   = 32;   // column score, signed
    localparam int ACC_W   = 48;   // profile accumulator, signed

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic signed [W_W-1:0] MATCH_RESET    = 5'sd1;
    localparam logic signed [W_W-1:0] MISMATCH_RESET = -5'sd2;
    localparam logic signed [W_W-1:0] GAP_RESET      = -5'sd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH    = 2'd0,
        CFG_MISMATCH = 2'd1,
        CFG_GAP      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [W_W-1:0] match;
        logic signed [W_W-1:0] mismatch;
        logic signed [W_W-1:0] gap;
    } t_weights;

    typedef struct packed {
        logic [NUM_BASES-1:0][CNT_W-1:0] cnt;
        logic [CNT_W-1:0]                gap;
        logic [SUM_W-1:0]                base_sum;
        logic                            last;
    } t_col;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'(MAX_COVERAGE);
        return (c > lim) ? lim : c;
    endfunction

endpackage

@@ src/psp_front.sv @@
module psp_front import psp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [IN_DATA_W-1:0] i_data,
    input  logic                 i_last,
    output logic                 o_ready,
    output logic                 o_valid,
    output t_col                 o_col,
    input  logic                 i_ready
);

    logic r_valid;
    t_col r_col;
    t_col n_col;

    // Clamp the counts and form the base sum used by the pair and gap terms
    always_comb begin
        n_col = '0;
        for (int b = 0; b < NUM_BASES; b++) begin
            n_col.cnt[b] = clamp_count(i_data[b*CNT_W +: CNT_W]);
            n_col.base_sum = n_col.base_sum + SUM_W'(n_col.cnt[b]);
        end
        n_col.gap  = clamp_count(i_data[NUM_BASES*CNT_W +: CNT_W]);
        n_col.last = i_last;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_col   = r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_col <= n_col;
        end
    end

endmodule

@@ src/psp_queue.sv @@
module psp_queue import psp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_col    i_col,
    output logic    o_ready,
    output logic    o_valid,
    output t_col    o_col,
    input  logic    i_ready,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_col          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_ready      = !o_stat.full;
    assign o_valid      = !o_stat.empty;
    assign o_col        = r_mem[r_rd];
    assign push         = i_valid && o_ready;
    assign pop          = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_col;
        end
    end

endmodule

@@ src/psp_back.sv @@
module psp_back import psp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_weights         i_weights,
    input  logic             i_valid,
    input  t_col             i_col,
    output logic             o_ready,
    output logic             o_valid,
    output logic [ACC_W-1:0] o_total,
    output logic             o_sat,
    input  logic             i_ready
);

    logic en;

    // Stage 1: squares and sums
    logic                 r_v1;
    logic                 r_last1;
    logic [SQSUM_W-1:0]   r_m1;
    logic [SQSUM_W-1:0]   r_q1;
    logic [S2_W-1:0]      r_s21;
    logic [GS_W-1:0]      r_gs1;
    logic [SQSUM_W-1:0]   n_m1;
    logic [SQSUM_W-1:0]   n_q1;
    logic [SQ_W-1:0]      sq;

    // Stage 2: weighted column score
    logic                     r_v2;
    logic                     r_last2;
    logic signed [COL_W-1:0]  r_col2;
    logic [S2_W-1:0]          diff;
    logic [PAIR_W-1:0]        pair;
    logic signed [PROD_W-1:0] p_match;
    logic signed [PROD_W-1:0] p_mism;
    logic signed [PROD_W-1:0] p_gap;
    logic signed [COL_W-1:0]  n_col2;

    // Stage 3: accumulate and emit
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_clip;
    logic                    r_out_valid;
    logic [ACC_W-1:0]        r_out_total;
    logic                    r_out_sat;
    logic signed [ACC_W:0]   sum;
    logic                    ovf;
    logic signed [ACC_W-1:0] sat_sum;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_valid;
    assign o_total = r_out_total;
    assign o_sat   = r_out_sat;

    // (c-1)^2 = c^2 - 2c + 1, taken only for counts above one
    always_comb begin
        n_m1 = '0;
        n_q1 = '0;
        sq   = '0;
        for (int b = 0; b < NUM_BASES; b++) begin
            sq   = i_col.cnt[b] * i_col.cnt[b];
            n_q1 = n_q1 + SQSUM_W'(sq);
            if (i_col.cnt[b] > CNT_W'(1)) begin
                n_m1 = n_m1 + SQSUM_W'(sq - {i_col.cnt[b], 1'b0} + SQ_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_m1    <= n_m1;
            r_q1    <= n_q1;
            r_s21   <= i_col.base_sum * i_col.base_sum;
            r_gs1   <= i_col.gap * i_col.base_sum;
            r_last1 <= i_col.last;
        end
    end

    // Sum over distinct pairs is (S^2 - sum of squares) / 2, always even
    always_comb begin
        diff    = r_s21 - S2_W'(r_q1);
        pair    = PAIR_W'(diff >> 1);
        p_match = PROD_W'(i_weights.match) * $signed(PROD_W'(r_m1));
        p_mism  = PROD_W'(i_weights.mismatch) * $signed(PROD_W'(pair));
        p_gap   = PROD_W'(i_weights.gap) * $signed(PROD_W'(r_gs1));
        n_col2  = COL_W'(p_match) + COL_W'(p_mism) + COL_W'(p_gap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v1) begin
            r_col2  <= n_col2;
            r_last2 <= r_last1;
        end
    end

    // Saturating accumulate
    always_comb begin
        sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_col2);
        ovf = sum[ACC_W] != sum[ACC_W-1];
        if (!ovf) begin
            sat_sum = sum[ACC_W-1:0];
        end else if (sum[ACC_W]) begin
            sat_sum = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            sat_sum = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v2 && r_last2;
            if (r_v2) begin
                if (r_last2) begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_acc  <= sat_sum;
                    r_clip <= r_clip || ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v2 && r_last2) begin
            r_out_total <= sat_sum;
            r_out_sat   <= r_clip || ovf;
        end
    end

endmodule

@@ src/profile_sum_of_pairs_score.sv @@
// Sum-of-pairs profile scorer.
//
// Slave stream (i_s_*): one transaction per alignment column. tdata carries
// the six clamped-to-coverage counts A, C, G, T, N, gap; tlast marks the final
// column of a profile. Master stream (o_m_*): one transaction per profile,
// the saturated 48-bit signed total in tdata and the clip flag in tuser.
// Config channel (i_cfg_*): index 0 match, 1 mismatch, 2 gap weight, 5-bit
// signed; other indexes are dropped. o_cfg_ready is always high.
//
// Throughput: one column per cycle while the receiver does not stall the output, set by
// the three-stage scoring pipeline behind a small column queue. The total appears on
// o_m_tvalid once the last column has passed the front register, queue, square stage,
// weight stage and accumulate/output register.
// Reset clears the accumulator, clip flag, queue and output, and restores the
// default weights (match 1, mismatch -2, gap -2). When the receiver stalls,
// the output register holds its total and the back end halts; the queue keeps
// taking columns until it and the front register fill, then o_s_tready drops.
module profile_sum_of_pairs_score import psp_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,    // count_a, count_c, count_g, count_t,
                                               // count_n, count_gap; 4 bits pad
    input  logic                 i_s_tlast,    // last_column
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [ACC_W-1:0]     o_m_tdata,    // total_score
    output logic                 o_m_tuser,    // saturated
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [W_W-1:0]       i_cfg_data
);

    t_weights r_weights;
    logic     f_valid;
    t_col     f_col;
    logic     q_ready;
    logic     q_valid;
    t_col     q_col;
    t_q_stat  q_stat;
    logic     b_ready;

    assign o_cfg_ready = 1'b1;

    // Weight registers; the user must make writes only while the pipeline is idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.match    <= MATCH_RESET;
            r_weights.mismatch <= MISMATCH_RESET;
            r_weights.gap      <= GAP_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MATCH:    r_weights.match    <= i_cfg_data;
                CFG_MISMATCH: r_weights.mismatch <= i_cfg_data;
                CFG_GAP:      r_weights.gap      <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Front: accept and clamp the column
    psp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .o_valid (f_valid),
        .o_col   (f_col),
        .i_ready (q_ready)
    );

    // Queue decoupling front and back
    psp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_col   (f_col),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_col   (q_col),
        .i_ready (b_ready),
        .o_stat  (q_stat)
    );

    // Back: score, accumulate, emit on the last column
    psp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_weights (r_weights),
        .i_valid   (q_valid),
        .i_col     (q_col),
        .o_ready   (b_ready),
        .o_valid   (o_m_tvalid),
        .o_total   (o_m_tdata),
        .o_sat     (o_m_tuser),
        .i_ready   (i_m_tready)
    );

    // Queue occupancy can never read full and empty at once
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // A column held in the front register is not lost while the queue is full
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid && !q_ready |=> f_valid)
        else $error("front register dropped a column");

    // The front only advances into a queue that has room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !q_ready)
        else $error("queue accepted a column while full");

endmodule
